// ===== hw/rtl/bit_allocation_map_core_macros.svh =====
// assertion macros shared by the bit allocation map rtl
// no dependencies; included by files that carry concurrent checks
`ifndef BIT_ALLOCATION_MAP_CORE_MACROS_SVH
`define BIT_ALLOCATION_MAP_CORE_MACROS_SVH

// same-cycle implication, checks off while in reset
`define BAM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checks off while in reset
`define BAM_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bam_pkg.sv =====
// types, codes and helper functions of the bit allocation map
// no dependencies; imported by bam_seq, the top level and the testbench
package bam_pkg;

  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;
  localparam int OPC_W      = 3;
  localparam int IDX_W      = 10;
  localparam int CFG_W      = 11;
  localparam int STAT_W     = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  localparam logic [PADDR_W-1:0] REG_BITS_IN_USE = 3'd0;

  localparam logic [OPC_W-1:0] OP_SET        = 3'd0;
  localparam logic [OPC_W-1:0] OP_CLEAR      = 3'd1;
  localparam logic [OPC_W-1:0] OP_TEST       = 3'd2;
  localparam logic [OPC_W-1:0] OP_FIND_SET   = 3'd3;
  localparam logic [OPC_W-1:0] OP_FIND_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SCAN
  } seq_state_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [IDX_W-1:0] bit_index;
  } bam_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              bit_value;
    logic [IDX_W-1:0]  found_index;
  } bam_rsp_t;

  // position of the lowest set bit, binary search over halves
  function automatic logic [WORD_SHIFT-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0]  w;
    logic [WORD_BITS-1:0]  low_mask;
    logic [WORD_SHIFT-1:0] pos;
    w   = v;
    pos = '0;
    for (int k = WORD_SHIFT - 1; k >= 0; k--) begin
      low_mask = (WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1);
      if ((w & low_mask) == '0) begin
        pos[k] = 1'b1;
        w      = w >> (1 << k);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/bam_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing; used for the bit store
module bam_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/bam_seq.sv =====
// sequencer of the bit allocation map: clearing pass, read-modify-write, word scan
// depends on bam_pkg and the assertion macro header; drives one bam_ram
`include "bit_allocation_map_core_macros.svh"

module bam_seq import bam_pkg::*; #(
  parameter int MAX_BITS = 1024,
  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS,
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  bam_req_t             req,
  input  logic [CFG_W-1:0]     cfg_size,
  output logic                 done,
  output bam_rsp_t             rsp,
  output logic [ADDR_W-1:0]    ram_rd_addr,
  input  logic [WORD_BITS-1:0] ram_rd_data,
  output logic                 ram_wr_en,
  output logic [ADDR_W-1:0]    ram_wr_addr,
  output logic [WORD_BITS-1:0] ram_wr_data
);

  localparam int CNT_W = ($clog2(MAX_BITS + 1) > CFG_W) ? $clog2(MAX_BITS + 1) : CFG_W;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
  localparam logic [CNT_W-1:0]  MAX_LIMIT = CNT_W'(MAX_BITS);

  seq_state_t state, state_next;

  logic [ADDR_W-1:0] word_ptr, word_ptr_next;
  logic [OPC_W-1:0]  op_q;
  logic [IDX_W-1:0]  idx_q;
  logic              done_next;
  bam_rsp_t          rsp_next;

  logic [CNT_W-1:0] size_ext, limit, lim_word;
  logic [WORD_SHIFT-1:0] lim_off;
  logic             accept, is_bitop, is_find, in_range;
  logic [ADDR_W-1:0] req_word, q_word;
  logic             word_full, word_part, scan_last, hit;
  logic [WORD_BITS-1:0] valid_mask, cand, bit_mask;
  logic [WORD_SHIFT-1:0] hit_pos;

  // size in use, saturated at the storage size
  assign size_ext = CNT_W'(cfg_size);
  assign limit    = (size_ext > MAX_LIMIT) ? MAX_LIMIT : size_ext;
  assign lim_word = limit >> WORD_SHIFT;
  assign lim_off  = limit[WORD_SHIFT-1:0];

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign is_bitop = (req.opcode == OP_SET) || (req.opcode == OP_CLEAR) ||
                    (req.opcode == OP_TEST);
  assign is_find  = (req.opcode == OP_FIND_SET) || (req.opcode == OP_FIND_CLEAR);
  assign in_range = CNT_W'(req.bit_index) < limit;
  assign req_word = ADDR_W'(req.bit_index >> WORD_SHIFT);
  assign q_word   = ADDR_W'(idx_q >> WORD_SHIFT);
  assign bit_mask = WORD_BITS'(1) << idx_q[WORD_SHIFT-1:0];

  // bits of the word under scan that lie below the size in use
  assign word_full  = CNT_W'(word_ptr) < lim_word;
  assign word_part  = CNT_W'(word_ptr) == lim_word;
  assign valid_mask = word_full ? '1 :
                      word_part ? ((WORD_BITS'(1) << lim_off) - WORD_BITS'(1)) : '0;
  assign cand       = ((op_q == OP_FIND_SET) ? ram_rd_data : ~ram_rd_data) & valid_mask;
  assign hit        = |cand;
  assign hit_pos    = lowest_one(cand);
  assign scan_last  = (word_ptr == LAST_WORD) || !word_full;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (word_ptr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && is_find) begin
          state_next = S_SCAN;
        end else if (accept && is_bitop && in_range) begin
          state_next = S_RMW;
        end
      end
      S_RMW: begin
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (hit || scan_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_rd_addr   = '0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = word_ptr;
    ram_wr_data   = '0;
    word_ptr_next = word_ptr;
    done_next     = 1'b0;
    rsp_next      = '0;
    case (state)
      S_CLEAR: begin
        ram_wr_en     = 1'b1;
        word_ptr_next = (word_ptr == LAST_WORD) ? '0 : word_ptr + ADDR_W'(1);
      end
      S_IDLE: begin
        ram_rd_addr = is_find ? '0 : req_word;
        if (accept) begin
          word_ptr_next = '0;
          if (!is_find && !(is_bitop && in_range)) begin
            done_next       = 1'b1;
            rsp_next.status = is_bitop ? ST_RANGE : ST_OK;
          end
        end
      end
      S_RMW: begin
        ram_wr_addr        = q_word;
        ram_wr_en          = (op_q != OP_TEST);
        ram_wr_data        = (op_q == OP_SET) ? (ram_rd_data | bit_mask)
                                              : (ram_rd_data & ~bit_mask);
        done_next          = 1'b1;
        rsp_next.bit_value = (op_q == OP_TEST) && ((ram_rd_data & bit_mask) != '0);
      end
      S_SCAN: begin
        ram_rd_addr = word_ptr + ADDR_W'(1);
        if (hit) begin
          done_next            = 1'b1;
          rsp_next.found_index = IDX_W'({word_ptr, hit_pos});
        end else if (scan_last) begin
          done_next       = 1'b1;
          rsp_next.status = ST_NONE;
        end else begin
          word_ptr_next = word_ptr + ADDR_W'(1);
        end
      end
      default: begin
        word_ptr_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      word_ptr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      word_ptr <= word_ptr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      rsp <= rsp_next;
    end
    if (accept) begin
      op_q  <= req.opcode;
      idx_q <= req.bit_index;
    end
  end

  `BAM_ASSERT_IMP(a_wr_in_clear_or_rmw, clk, rst, ram_wr_en, (state == S_CLEAR) || (state == S_RMW), "bit store written outside clear or rmw")
  `BAM_ASSERT_NXT(a_rmw_single_cycle, clk, rst, state == S_RMW, (state == S_IDLE) && done, "rmw did not finish in one cycle")
  `BAM_ASSERT_NXT(a_accept_progress, clk, rst, start && !busy, busy || done, "accepted transaction neither busy nor done")
  `BAM_ASSERT_IMP(a_none_zero_fields, clk, rst, done && (rsp.status == ST_NONE), (rsp.found_index == '0) && !rsp.bit_value, "no-match result carries data")

endmodule

// ===== hw/rtl/bit_allocation_map_core.sv =====
// top level of the bit allocation map: apb size register, bit store ram, sequencer
// depends on bam_pkg, bam_ram and bam_seq
//
// A bit map of MAX_BITS bits kept as 64-bit words in one synchronous ram, with
// set, clear, test, find-lowest-set and find-lowest-clear commands. A transaction
// is taken when start is high and busy is low; its result appears on rsp for
// exactly one cycle with done high, and the receiver cannot stall it. An in-range
// set, clear or test reads its word at the accept, then does the read-modify-write;
// an out-of-range index or an undefined opcode is answered from the accept alone.
// A find reads the first word at the accept; the scan then reads one word per cycle
// through the ram's single read port and stops at the first word with a match, at
// the word that holds the end of the size in use, or at the last word. The done
// strobe follows in the cycle after the last step, and busy drops in that same
// cycle, so a new transaction can be taken while the previous result is shown.
// After reset a clearing pass writes zero to every word with busy high; the size
// register can be written through apb meanwhile.
// bits_in_use is meant to be changed only while the block is idle; values above
// MAX_BITS act as MAX_BITS, and a size of zero rejects every index.
module bit_allocation_map_core import bam_pkg::*; #(
  parameter int MAX_BITS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  bam_req_t           req,
  output logic               done,
  output bam_rsp_t           rsp,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [CFG_W-1:0]     bits_in_use;
  logic                 cfg_wr;

  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [WORD_BITS-1:0] ram_rd_data;
  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;

  // apb: zero wait states, write lands in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_BITS_IN_USE);
  assign prdata = (paddr == REG_BITS_IN_USE) ? PDATA_W'(bits_in_use) : '0;

  // size register, full 11-bit value kept; saturation happens in the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= CFG_SIZE_RESET;
    end else if (cfg_wr) begin
      bits_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // bit store: one word per entry, bit i in word i/64 at position i%64
  bam_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // command sequencing; busy interlocks the read-modify-write so no
  // read of a word can overlap its pending write
  bam_seq #(
    .MAX_BITS (MAX_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .cfg_size    (bits_in_use),
    .done        (done),
    .rsp         (rsp),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for bit_allocation_map_core: directed and random commands
// depends on bam_pkg and the core rtl; a class tracks the expected bit map state
`timescale 1ns / 1ps

module tb import bam_pkg::*;;

  localparam int MAX_BITS       = 1024;
  localparam int NUM_WORDS      = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PASS = 100;

  localparam logic [PADDR_W-1:0] REG_UNUSED  = REG_BITS_IN_USE + 3'd4;
  localparam logic [OPC_W-1:0]   OP_UNDEF_LO = OP_FIND_CLEAR + 3'd1;
  localparam logic [OPC_W-1:0]   OP_UNDEF_HI = '1;

  // expected bit map, size register and pending responses
  class bitmap_tracker;
    logic [WORD_BITS-1:0] words[NUM_WORDS];
    logic [CFG_W-1:0]     size_cfg;
    bam_rsp_t             expected_rsps[$];
    int                   errors;

    function new();
      foreach (words[w]) words[w] = '0;
      size_cfg = CFG_SIZE_RESET;
      errors   = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_cfg = v;
    endfunction

    function void check_size(logic [PDATA_W-1:0] rd);
      if (rd !== PDATA_W'(size_cfg))
        flag($sformatf("size readback exp %0d got %0d", size_cfg, rd));
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    // apply one command to the map and work out its response
    function bam_rsp_t apply_command(bam_req_t c);
      bam_rsp_t r;
      int       lim;
      int       hit;
      int       w;
      int       b;
      r   = '0;
      lim = (size_cfg > MAX_BITS) ? MAX_BITS : int'(size_cfg);
      w   = int'(c.bit_index) / WORD_BITS;
      b   = int'(c.bit_index) % WORD_BITS;
      case (c.opcode)
        OP_SET, OP_CLEAR, OP_TEST: begin
          if (int'(c.bit_index) >= lim) begin
            r.status = ST_RANGE;
          end else if (c.opcode == OP_SET) begin
            words[w][b] = 1'b1;
          end else if (c.opcode == OP_CLEAR) begin
            words[w][b] = 1'b0;
          end else begin
            r.bit_value = words[w][b];
          end
        end
        OP_FIND_SET, OP_FIND_CLEAR: begin
          hit = -1;
          for (int i = 0; i < lim && hit < 0; i++)
            if (words[i / WORD_BITS][i % WORD_BITS] == (c.opcode == OP_FIND_SET)) hit = i;
          if (hit < 0) r.status = ST_NONE;
          else r.found_index = IDX_W'(hit);
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_command(bam_req_t c);
      expected_rsps.push_back(apply_command(c));
    endfunction

    function void check_response(bam_rsp_t got);
      bam_rsp_t exp;
      if (expected_rsps.size() == 0) begin
        flag($sformatf("response %p with nothing pending", got));
        return;
      end
      exp = expected_rsps.pop_front();
      if (got.status !== exp.status)
        flag($sformatf("status exp %0d got %0d", exp.status, got.status));
      if (got.bit_value !== exp.bit_value)
        flag($sformatf("bit_value exp %0d got %0d", exp.bit_value, got.bit_value));
      if (got.found_index !== exp.found_index)
        flag($sformatf("found_index exp %0d got %0d", exp.found_index, got.found_index));
    endfunction
  endclass

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  logic               busy;
  bam_req_t           req     = '0;
  logic               done;
  bam_rsp_t           rsp;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bitmap_tracker tracker = new();
  int            idle_cycles = 0;

  bit_allocation_map_core #(.MAX_BITS(MAX_BITS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor: the result shown now belongs to an older transaction, so check
  // it before noting the command taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_response(rsp);
      if (start && !busy) tracker.note_command(req);
    end
  end

  // watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic bam_req_t cmd(logic [OPC_W-1:0] op, int idx);
    bam_req_t c;
    c.opcode    = op;
    c.bit_index = IDX_W'(idx);
    return c;
  endfunction

  // all tasks below are entered just after a rising edge
  // present one transaction and hold it until the block takes it
  task automatic send(bam_req_t c);
    start <= 1'b1;
    req   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and wait until every response has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write; the bus goes idle after the access phase before the task returns
  task automatic apb_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (a == REG_BITS_IN_USE) tracker.set_size(d[CFG_W-1:0]);
    @(posedge clk);
  endtask

  task automatic apb_read_check(logic [PADDR_W-1:0] a);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // access edge: prdata sampled before the block updates
    tracker.check_size(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // size write with random upper bits, then read it back
  task automatic config_size(int size);
    logic [PDATA_W-1:0] d;
    d = $urandom;
    d[CFG_W-1:0] = CFG_W'(size);
    apb_write(REG_BITS_IN_USE, d);
    apb_read_check(REG_BITS_IN_USE);
  endtask

  // random command, mostly in range, weighted toward sets or clears
  function automatic bam_req_t random_command(int lim, bit fill);
    bam_req_t c;
    int       roll;
    int       idx;
    roll = $urandom_range(0, 99);
    if (lim > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, lim - 1);
    else idx = $urandom_range(0, MAX_BITS - 1);
    if (roll < 40)      c = cmd(fill ? OP_SET : OP_CLEAR, idx);
    else if (roll < 50) c = cmd(fill ? OP_CLEAR : OP_SET, idx);
    else if (roll < 65) c = cmd(OP_TEST, idx);
    else if (roll < 80) c = cmd(OP_FIND_SET, idx);
    else if (roll < 97) c = cmd(OP_FIND_CLEAR, idx);
    else c = cmd(OP_FIND_CLEAR + 3'($urandom_range(1, OP_UNDEF_HI - OP_FIND_CLEAR)), idx);
    return c;
  endfunction

  // one random pass: bursts of back-to-back commands with random gaps
  task automatic random_pass(int size, int items, bit fill);
    int lim;
    int left;
    int burst;
    int gap;
    config_size(size);
    lim  = (size > MAX_BITS) ? MAX_BITS : size;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && left > 0; k++) begin
        send(random_command(lim, fill));
        left--;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // reset value of the size register, read during the clearing pass
    apb_read_check(REG_BITS_IN_USE);

    // full size: empty map, both ends, lowest-set behavior, undefined opcodes
    send(cmd(OP_FIND_SET, 0));
    send(cmd(OP_FIND_CLEAR, 1023));
    send(cmd(OP_SET, 0));
    send(cmd(OP_SET, 1023));
    send(cmd(OP_TEST, 1023));
    send(cmd(OP_FIND_SET, 0));
    send(cmd(OP_CLEAR, 0));
    send(cmd(OP_FIND_SET, 0));
    send(cmd(OP_FIND_CLEAR, 0));
    send(cmd(OP_UNDEF_LO, 1023));
    send(cmd(OP_UNDEF_HI, 1023));
    send(cmd(OP_TEST, 0));
    settle();

    // size of zero rejects every index and finds nothing
    apb_write(REG_BITS_IN_USE, 32'hFFFF_F800);
    apb_read_check(REG_BITS_IN_USE);
    send(cmd(OP_SET, 0));
    send(cmd(OP_TEST, 0));
    send(cmd(OP_FIND_CLEAR, 0));
    settle();

    // write to an address with no register has no effect
    apb_write(REG_UNUSED, 32'd5);
    apb_read_check(REG_BITS_IN_USE);
    send(cmd(OP_FIND_SET, 0));
    settle();

    // size above the maximum acts as the maximum
    config_size(2047);
    send(cmd(OP_TEST, 1023));
    send(cmd(OP_FIND_SET, 0));
    settle();

    // one partial word fully set, bits beyond the size ignored
    config_size(8);
    for (int i = 0; i < 8; i++) send(cmd(OP_SET, i));
    send(cmd(OP_FIND_CLEAR, 0));
    send(cmd(OP_TEST, 8));
    settle();

    // random passes over several sizes, mixing fill and drain
    random_pass(1024, ITEMS_PER_PASS, 1'b1);
    random_pass(70, ITEMS_PER_PASS, 1'b1);
    random_pass(1, ITEMS_PER_PASS / 2, 1'b0);
    random_pass(2047, ITEMS_PER_PASS, 1'b0);
    random_pass(65, ITEMS_PER_PASS, 1'b1);
    random_pass(0, ITEMS_PER_PASS / 4, 1'b1);
    random_pass($urandom_range(1, 1024), ITEMS_PER_PASS, 1'b0);
    random_pass(200, ITEMS_PER_PASS, 1'b1);
    random_pass(1025, ITEMS_PER_PASS, 1'b0);

    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
